// ----- src/ivst_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the interrupt vector service tracker.
// No dependencies; used by interrupt_vector_service_tracker.
package ivst_pkg;

  // Operation codes on the func field
  localparam logic [1:0] FUNC_RAISE = 2'd0;
  localparam logic [1:0] FUNC_ACK   = 2'd1;
  localparam logic [1:0] FUNC_EOI   = 2'd2;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int VEC_W  = 8;
  localparam int IRQ_W  = 6;
  localparam int SRC_W  = 4;

  // Priority class is the vector divided by 16
  localparam int CLS_W       = 4;
  localparam int CLASS_SHIFT = 4;
  localparam int CLASS_SIZE  = 16;

  // Source table entry: valid flag over the source id
  localparam int SRC_ENT_W = SRC_W + 1;

  // Sizes
  localparam int NUM_VECTORS_DEF = 256;
  localparam int NUM_PINS        = 64;
  localparam int NUM_SOURCES     = 16;

endpackage

// ----- src/interrupt_vector_service_tracker.sv -----
`timescale 1ns / 1ps
// Interrupt vector service tracker: request / in-service / level bitmaps,
// two-step priority search and the per-vector pin and source memories.
// Depends on ivst_pkg.
//
// Each transfer steps through the find (class search), execute (vector search
// and memory access) and response (memory read data) states, and out_valid is
// registered as the response state ends. A new transfer is taken only in idle;
// a result held by out_ready low holds off the next transfer.
// Reset clears the bitmaps, the state machine and the out_valid flag. The pin
// and source memories need no clearing pass: an entry is read only for a
// vector whose request bit was set, and setting it writes that entry.
module interrupt_vector_service_tracker #(
  parameter int NUM_VECTORS = ivst_pkg::NUM_VECTORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ivst_pkg::FUNC_W-1:0] func,
  input  logic [ivst_pkg::VEC_W-1:0] vector,
  input  logic [ivst_pkg::IRQ_W-1:0] irq,
  input  logic                       reraise,
  input  logic                       level_source,
  input  logic                       source_present,
  input  logic [ivst_pkg::SRC_W-1:0] source_id,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       ack_valid,
  output logic [ivst_pkg::VEC_W-1:0] ack_vector,
  output logic [ivst_pkg::IRQ_W-1:0] ack_irq,
  output logic                       eoi_done,
  output logic [ivst_pkg::VEC_W-1:0] eoi_vector,
  output logic                       eoi_notify,
  output logic [ivst_pkg::IRQ_W-1:0] eoi_irq,
  output logic [ivst_pkg::SRC_W-1:0] eoi_source
);

  localparam int CLASS_SIZE = ivst_pkg::CLASS_SIZE;
  localparam int GROUPS     = (NUM_VECTORS + CLASS_SIZE - 1) / CLASS_SIZE;
  localparam int VEC_AW     = $clog2(NUM_VECTORS);
  localparam int GRP_W      = VEC_AW - ivst_pkg::CLASS_SHIFT;
  localparam int CLS_W      = ivst_pkg::CLS_W;
  localparam int POS_W      = ivst_pkg::CLASS_SHIFT;
  localparam int VEC_W      = ivst_pkg::VEC_W;
  localparam int IRQ_W      = ivst_pkg::IRQ_W;
  localparam int SRC_W      = ivst_pkg::SRC_W;
  localparam int SRC_ENT_W  = ivst_pkg::SRC_ENT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIND = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  typedef logic [GROUPS-1:0][CLASS_SIZE-1:0] bitmap_t;

  typedef struct packed {
    logic [1:0]       func;
    logic             ack_valid;
    logic [VEC_W-1:0] ack_vector;
    logic             eoi_done;
    logic [VEC_W-1:0] eoi_vector;
    logic             was_level;
  } exec_res_t;

  // Highest nonempty class of a bitmap; 0 when empty
  function automatic logic [CLS_W-1:0] top_group(input bitmap_t m);
    logic [CLS_W-1:0] r;
    r = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (|m[g]) r = CLS_W'(g);
    end
    return r;
  endfunction

  // Highest set bit within one class; 0 when empty
  function automatic logic [POS_W-1:0] top_bit(input logic [CLASS_SIZE-1:0] b);
    logic [POS_W-1:0] r;
    r = '0;
    for (int i = 0; i < CLASS_SIZE; i++) begin
      if (b[i]) r = POS_W'(i);
    end
    return r;
  endfunction

  logic [1:0]         state;
  bitmap_t            req_map;
  bitmap_t            svc_map;
  bitmap_t            lvl_map;

  // latched input item
  logic [1:0]         op_func;
  logic [VEC_W-1:0]   op_vector;
  logic [IRQ_W-1:0]   op_irq;
  logic               op_reraise;
  logic               op_level;
  logic               op_spres;
  logic [SRC_W-1:0]   op_sid;

  logic [CLS_W-1:0]   req_cls;
  logic [CLS_W-1:0]   svc_cls;
  exec_res_t          res;

  // memories
  logic [IRQ_W-1:0]     pin_mem [NUM_VECTORS];
  logic [SRC_ENT_W-1:0] src_mem [NUM_VECTORS];
  logic [IRQ_W-1:0]     pin_rd;
  logic [SRC_ENT_W-1:0] src_rd;
  logic [VEC_AW-1:0]    mem_addr;
  logic                 pin_we;
  logic                 src_we;
  logic                 mem_re;
  logic [SRC_ENT_W-1:0] src_wdata;

  // execute-stage decode
  logic [POS_W-1:0]   req_pos;
  logic [POS_W-1:0]   svc_pos;
  logic [VEC_W-1:0]   req_vec;
  logic [VEC_W-1:0]   svc_vec;
  logic               raise_ok;
  logic               ack_ok;
  logic               eoi_ok;
  logic [GRP_W-1:0]   raise_grp;
  logic [POS_W-1:0]   raise_pos;
  logic               out_free;
  logic               pin_ok;
  logic               notify;

  assign in_ready = !rst && (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Decode the item in the execute cycle
  always_comb begin
    req_pos   = top_bit(req_map[req_cls[GRP_W-1:0]]);
    svc_pos   = top_bit(svc_map[svc_cls[GRP_W-1:0]]);
    req_vec   = {req_cls, req_pos};
    svc_vec   = {svc_cls, svc_pos};
    raise_ok  = (op_func == ivst_pkg::FUNC_RAISE)
              && (op_vector[VEC_W-1:POS_W] != '0)
              && ({1'b0, op_vector} < (VEC_W+1)'(NUM_VECTORS));
    ack_ok    = (op_func == ivst_pkg::FUNC_ACK) && (req_cls > svc_cls);
    eoi_ok    = (op_func == ivst_pkg::FUNC_EOI) && (svc_cls != '0);
    raise_grp = op_vector[VEC_AW-1:POS_W];
    raise_pos = op_vector[POS_W-1:0];
    src_wdata = '0;
    if (op_spres && ({3'b0, op_sid} < (SRC_W+3)'(ivst_pkg::NUM_SOURCES))) begin
      src_wdata = {1'b1, op_sid};
    end
    pin_we = (state == ST_EXEC) && raise_ok;
    src_we = (state == ST_EXEC) && raise_ok && op_level;
    mem_re = (state == ST_EXEC) && (ack_ok || eoi_ok);
    priority if (op_func == ivst_pkg::FUNC_ACK) begin
      mem_addr = req_vec[VEC_AW-1:0];
    end else if (op_func == ivst_pkg::FUNC_EOI) begin
      mem_addr = svc_vec[VEC_AW-1:0];
    end else begin
      mem_addr = op_vector[VEC_AW-1:0];
    end
  end

  // Pin and source memories: one port, read data registered
  always_ff @(posedge clk) begin
    if (pin_we) pin_mem[mem_addr] <= op_irq;
    if (mem_re) pin_rd <= pin_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[mem_addr] <= src_wdata;
    if (mem_re) src_rd <= src_mem[mem_addr];
  end

  // Sequencer, item latch, class search and result capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) state <= ST_FIND;
        ST_FIND: state <= ST_EXEC;
        ST_EXEC: state <= ST_RESP;
        ST_RESP: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_func    <= func;
      op_vector  <= vector;
      op_irq     <= irq;
      op_reraise <= reraise;
      op_level   <= level_source;
      op_spres   <= source_present;
      op_sid     <= source_id;
    end
    if (state == ST_FIND) begin
      req_cls <= top_group(req_map);
      svc_cls <= top_group(svc_map);
    end
    if (state == ST_EXEC) begin
      res.func       <= op_func;
      res.ack_valid  <= ack_ok;
      res.ack_vector <= req_vec;
      res.eoi_done   <= eoi_ok;
      res.eoi_vector <= svc_vec;
      res.was_level  <= lvl_map[svc_cls[GRP_W-1:0]][svc_pos];
    end
  end

  // Modify the bitmaps in the execute cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      req_map <= '0;
      svc_map <= '0;
      lvl_map <= '0;
    end else if (state == ST_EXEC) begin
      if (raise_ok) begin
        if (op_reraise) svc_map[raise_grp][raise_pos] <= 1'b0;
        req_map[raise_grp][raise_pos] <= 1'b1;
        if (op_level) lvl_map[raise_grp][raise_pos] <= 1'b1;
      end
      if (ack_ok) begin
        req_map[req_cls[GRP_W-1:0]][req_pos] <= 1'b0;
        svc_map[req_cls[GRP_W-1:0]][req_pos] <= 1'b1;
      end
      if (eoi_ok) begin
        svc_map[svc_cls[GRP_W-1:0]][svc_pos] <= 1'b0;
        lvl_map[svc_cls[GRP_W-1:0]][svc_pos] <= 1'b0;
      end
    end
  end

  // Build the result from the captured decision and the memory read data
  assign pin_ok = ({3'b0, pin_rd} < (IRQ_W+3)'(ivst_pkg::NUM_PINS));
  assign notify = res.eoi_done && res.was_level && src_rd[SRC_W] && pin_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      ack_valid  <= res.ack_valid;
      ack_vector <= (res.func == ivst_pkg::FUNC_ACK) ? res.ack_vector : '0;
      ack_irq    <= res.ack_valid ? pin_rd : '0;
      eoi_done   <= res.eoi_done;
      eoi_vector <= res.eoi_done ? res.eoi_vector : '0;
      eoi_notify <= notify;
      eoi_irq    <= notify ? pin_rd : '0;
      eoi_source <= notify ? src_rd[SRC_W-1:0] : '0;
    end
  end

  // A result appears only after the response cycle
  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("result presented outside the response cycle");

  // The memory port never writes and reads in one cycle
  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    !(pin_we && mem_re))
    else $error("memory write and read collide");

  // An acknowledged vector lies above the lowest class and is never reported with a retirement
  a_ack_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && ack_valid |-> ack_vector[VEC_W-1:POS_W] != '0 && !eoi_done)
    else $error("acknowledge of a low-class vector");

  // A notification only follows a retired vector
  a_notify_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && eoi_notify |-> eoi_done)
    else $error("end of interrupt notification without retirement");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for interrupt_vector_service_tracker: directed and random
// raise / acknowledge / EOI traffic, checked against an in-bench priority predictor.
// Depends on ivst_pkg and interrupt_vector_service_tracker.
module testbench;

  localparam int FUNC_W          = ivst_pkg::FUNC_W;
  localparam int VEC_W           = ivst_pkg::VEC_W;
  localparam int IRQ_W           = ivst_pkg::IRQ_W;
  localparam int SRC_W           = ivst_pkg::SRC_W;
  localparam int SRC_ENT_W       = ivst_pkg::SRC_ENT_W;
  localparam int CLASS_SIZE      = ivst_pkg::CLASS_SIZE;
  localparam int CLASS_SHIFT     = ivst_pkg::CLASS_SHIFT;
  localparam int NUM_VECTORS_DEF = ivst_pkg::NUM_VECTORS_DEF;
  localparam int NUM_PINS        = ivst_pkg::NUM_PINS;
  localparam int NUM_SOURCES     = ivst_pkg::NUM_SOURCES;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         DRAIN_CYCLES = 12;

  typedef struct packed {
    logic                ack_valid;
    logic [VEC_W-1:0]    ack_vector;
    logic [IRQ_W-1:0]    ack_irq;
    logic                eoi_done;
    logic [VEC_W-1:0]    eoi_vector;
    logic                eoi_notify;
    logic [IRQ_W-1:0]    eoi_irq;
    logic [SRC_W-1:0]    eoi_source;
  } service_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   func;
  logic [VEC_W-1:0]    vector;
  logic [IRQ_W-1:0]    irq;
  logic                reraise;
  logic                level_source;
  logic                source_present;
  logic [SRC_W-1:0]    source_id;
  logic                out_valid;
  logic                out_ready;
  logic                ack_valid;
  logic [VEC_W-1:0]    ack_vector;
  logic [IRQ_W-1:0]    ack_irq;
  logic                eoi_done;
  logic [VEC_W-1:0]    eoi_vector;
  logic                eoi_notify;
  logic [IRQ_W-1:0]    eoi_irq;
  logic [SRC_W-1:0]    eoi_source;

  // Predictor copy of the interrupt state
  logic [NUM_VECTORS_DEF-1:0] pending_map;
  logic [NUM_VECTORS_DEF-1:0] in_service_map;
  logic [NUM_VECTORS_DEF-1:0] level_map;
  logic [IRQ_W-1:0]           pin_of [NUM_VECTORS_DEF];
  logic [SRC_ENT_W-1:0]       source_of [NUM_VECTORS_DEF];

  service_result_t pending_results [$];

  int errors;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;
  int results_checked;
  int n_raise, n_ack, n_ack_granted, n_eoi, n_eoi_notify, n_unused;

  interrupt_vector_service_tracker dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .vector         (vector),
    .irq            (irq),
    .reraise        (reraise),
    .level_source   (level_source),
    .source_present (source_present),
    .source_id      (source_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ack_valid      (ack_valid),
    .ack_vector     (ack_vector),
    .ack_irq        (ack_irq),
    .eoi_done       (eoi_done),
    .eoi_vector     (eoi_vector),
    .eoi_notify     (eoi_notify),
    .eoi_irq        (eoi_irq),
    .eoi_source     (eoi_source)
  );

  // Clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Highest set bit of a vector map, 0 when the map is empty
  function automatic int top_vector(logic [NUM_VECTORS_DEF-1:0] map);
    int i;
    for (i = NUM_VECTORS_DEF - 1; i >= 0; i--) begin
      if (map[i]) return i;
    end
    return 0;
  endfunction

  // Advance the predicted state by one transfer and return the expected result
  function automatic service_result_t service_step(
    logic [FUNC_W-1:0] op, logic [VEC_W-1:0] vec, logic [IRQ_W-1:0] pin,
    logic rer, logic lvl, logic sp, logic [SRC_W-1:0] sid);
    service_result_t  r;
    int               top_req;
    int               top_svc;
    logic [SRC_ENT_W-1:0] src;
    logic             was_level;
    r = '0;
    case (op)
      ivst_pkg::FUNC_RAISE: begin
        n_raise++;
        if (int'(vec) >= CLASS_SIZE && int'(vec) < NUM_VECTORS_DEF) begin
          if (rer) in_service_map[vec] = 1'b0;
          pending_map[vec] = 1'b1;
          if (lvl) begin
            source_of[vec] = (sp && int'(sid) < NUM_SOURCES) ? {1'b1, sid} : '0;
            level_map[vec] = 1'b1;
          end
          pin_of[vec] = pin;
        end
      end
      ivst_pkg::FUNC_ACK: begin
        n_ack++;
        top_req = top_vector(pending_map);
        top_svc = top_vector(in_service_map);
        r.ack_vector = top_req[VEC_W-1:0];
        if ((top_req >> CLASS_SHIFT) > (top_svc >> CLASS_SHIFT) && top_req >= CLASS_SIZE) begin
          pending_map[top_req]    = 1'b0;
          in_service_map[top_req] = 1'b1;
          r.ack_valid = 1'b1;
          r.ack_irq   = pin_of[top_req];
          n_ack_granted++;
        end
      end
      ivst_pkg::FUNC_EOI: begin
        n_eoi++;
        top_svc = top_vector(in_service_map);
        if (top_svc >= CLASS_SIZE && in_service_map[top_svc]) begin
          src       = source_of[top_svc];
          was_level = level_map[top_svc];
          in_service_map[top_svc] = 1'b0;
          level_map[top_svc]      = 1'b0;
          r.eoi_done   = 1'b1;
          r.eoi_vector = top_svc[VEC_W-1:0];
          if (was_level && src[SRC_ENT_W-1] && int'(pin_of[top_svc]) < NUM_PINS) begin
            r.eoi_notify = 1'b1;
            r.eoi_irq    = pin_of[top_svc];
            r.eoi_source = src[SRC_W-1:0];
            n_eoi_notify++;
          end
        end
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then record its expected result
  task automatic send_item(logic [FUNC_W-1:0] op, logic [VEC_W-1:0] vec,
                           logic [IRQ_W-1:0] pin, logic rer, logic lvl, logic sp,
                           logic [SRC_W-1:0] sid);
    // Idle cycle by cycle at the configured rate before offering
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= op;
    vector         <= vec;
    irq            <= pin;
    reraise        <= rer;
    level_source   <= lvl;
    source_present <= sp;
    source_id      <= sid;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(service_step(op, vec, pin, rer, lvl, sp, sid));
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int               pick;
    logic [FUNC_W-1:0] op;
    logic [VEC_W-1:0] vec;
    pick = int'($urandom_range(99));
    if (pick < 42)      op = ivst_pkg::FUNC_RAISE;
    else if (pick < 70) op = ivst_pkg::FUNC_ACK;
    else if (pick < 96) op = ivst_pkg::FUNC_EOI;
    else                op = FUNC_UNUSED;
    // Mostly serviceable vectors, sometimes the low reserved range
    if ($urandom_range(99) < 85) vec = VEC_W'($urandom_range(CLASS_SIZE, NUM_VECTORS_DEF - 1));
    else                         vec = VEC_W'($urandom_range(0, CLASS_SIZE - 1));
    send_item(op, vec, IRQ_W'($urandom_range(0, NUM_PINS - 1)), ($urandom_range(99) < 20),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              SRC_W'($urandom_range(0, NUM_SOURCES - 1)));
  endtask

  // Empty maps, unused code and low vectors that must be dropped
  task automatic test_empty_cases();
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_EOI, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(FUNC_UNUSED, 8'hFF, 6'h3F, 1'b1, 1'b1, 1'b1, 4'hF);
    send_item(ivst_pkg::FUNC_RAISE, 8'd0, 6'h3F, 1'b0, 1'b1, 1'b1, 4'hF);
    send_item(ivst_pkg::FUNC_RAISE, 8'd15, 6'h2A, 1'b1, 1'b1, 1'b1, 4'h5);
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
  endtask

  // Class ordering: a lower class is refused until the higher one retires
  task automatic test_priority_order();
    send_item(ivst_pkg::FUNC_RAISE, 8'd255, 6'h3F, 1'b0, 1'b1, 1'b1, 4'hF);
    send_item(ivst_pkg::FUNC_RAISE, 8'd16, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_EOI, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_EOI, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    // Same class as the one in service is refused
    send_item(ivst_pkg::FUNC_RAISE, 8'd40, 6'd7, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_RAISE, 8'd41, 6'd9, 1'b0, 1'b1, 1'b1, 4'd3);
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_EOI, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
  endtask

  // Level vector without a known source, then reraise of a vector in service
  task automatic test_level_and_reraise();
    send_item(ivst_pkg::FUNC_RAISE, 8'd100, 6'd33, 1'b0, 1'b1, 1'b0, 4'hA);
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_EOI, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_RAISE, 8'd200, 6'd21, 1'b0, 1'b1, 1'b1, 4'd0);
    send_item(ivst_pkg::FUNC_ACK, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_RAISE, 8'd200, 6'd22, 1'b1, 1'b0, 1'b0, 4'd0);
    send_item(ivst_pkg::FUNC_EOI, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    wait_drained();
  endtask

  task automatic test_random_phase(int sender_pct, int receiver_pct, int count);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (count) send_random_item();
    wait_drained();
  endtask

  // Stall the result side long enough that the input side backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold_left = 300;
    repeat (40) send_random_item();
    wait_drained();
  endtask

  // Result side: random stalls, or a held-off stretch counted down here
  always @(posedge clk) begin
    if (recv_hold_left > 0) begin
      recv_hold_left = recv_hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    service_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no expectation waiting", $time);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("ack_valid", 8'(want.ack_valid), 8'(ack_valid));
        check_field("ack_vector", want.ack_vector, ack_vector);
        check_field("ack_irq", 8'(want.ack_irq), 8'(ack_irq));
        check_field("eoi_done", 8'(want.eoi_done), 8'(eoi_done));
        check_field("eoi_vector", want.eoi_vector, eoi_vector);
        check_field("eoi_notify", 8'(want.eoi_notify), 8'(eoi_notify));
        check_field("eoi_irq", 8'(want.eoi_irq), 8'(eoi_irq));
        check_field("eoi_source", 8'(want.eoi_source), 8'(eoi_source));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    func           = ivst_pkg::FUNC_RAISE;
    vector         = '0;
    irq            = '0;
    reraise        = 1'b0;
    level_source   = 1'b0;
    source_present = 1'b0;
    source_id      = '0;
    out_ready      = 1'b0;
    pending_map    = '0;
    in_service_map = '0;
    level_map      = '0;
    foreach (pin_of[i]) pin_of[i] = '0;
    foreach (source_of[i]) source_of[i] = '0;
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_left = 0;
    results_checked = 0;
    n_raise = 0;
    n_ack = 0;
    n_ack_granted = 0;
    n_eoi = 0;
    n_eoi_notify = 0;
    n_unused = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_cases();
    test_priority_order();
    test_level_and_reraise();
    test_random_phase(37, 75, 400);
    test_random_phase(75, 37, 400);
    test_random_phase(0, 0, 400);
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d raises, %0d acknowledges (%0d granted), %0d EOIs (%0d notified),",
             n_raise, n_ack, n_ack_granted, n_eoi, n_eoi_notify);
    $display("%0d unused codes; %0d results checked with idle and stall patterns",
             n_unused, results_checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
